// ===== rtl/seg2d_pkg.sv =====
// ----------------------------------------------------------------------------
// seg2d_pkg: types and constants of the 2D segment intersection block
// Status codes, word layouts and internal arithmetic widths.
// ----------------------------------------------------------------------------
`default_nettype none
package seg2d_pkg;

   typedef enum logic [2:0] {
      ST_HIT      = 3'd0,
      ST_ZERO_LEN = 3'd1,
      ST_SHARED   = 3'd2,
      ST_NO_CROSS = 3'd3,
      ST_OUTSIDE  = 3'd4
   } status_type;

   localparam int COORD_W = 32;
   localparam int DIFF_W  = COORD_W + 1;    // endpoint difference
   localparam int PROD_W  = 2 * DIFF_W;     // one cross product term
   localparam int CROSS_W = PROD_W + 1;     // cross product
   localparam int DEN_W   = CROSS_W + 1;    // denominator, numerator
   localparam int QUO_W   = COORD_W;        // quotient bits (q <= |b - a|)
   localparam int LO_W    = 34;             // low slice of the numerator
   localparam int HI_W    = DEN_W - LO_W;
   localparam int NUM_W   = COORD_W + DEN_W; // |b - a| * num
   localparam int REQ_W   = 8 * COORD_W;
   localparam int RSP_W   = 72;

endpackage
`default_nettype wire

// ===== rtl/segment_intersection_2d_top.sv =====
// ----------------------------------------------------------------------------
// segment_intersection_2d_top: exact intersection of two 2D segments
// Throughput: one word per cycle while rsp_tready is high; each stage moves
//   on when the next is free; bubbles close up while the output is stalled.
// Depth is set by the 32-stage restoring divider, one quotient bit per stage.
// Reset: synchronous, active high; clears all stage valid bits.
// ----------------------------------------------------------------------------
`default_nettype none
module segment_intersection_2d_top (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   // a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y (32 bits each)
   input  wire logic [seg2d_pkg::REQ_W-1:0] req_tdata,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   // hit[0], status[3:1], cross_x[35:4], cross_y[67:36], zero pad[71:68]
   output logic [seg2d_pkg::RSP_W-1:0]   rsp_tdata
);
   import seg2d_pkg::*;

   localparam int DIV0 = 7;              // stage feeding the divider
   localparam int NS   = DIV0 + QUO_W + 2;

   logic [NS:1]   v_ff;
   logic [NS+1:1] en;

   always_comb begin
      en[NS+1] = rsp_tready;
      for (int k = NS; k >= 1; k--) begin
         en[k] = ~v_ff[k] | en[k+1];
      end
   end

   assign req_tready = en[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[1]) begin
            v_ff[1] <= req_tvalid;
         end
         for (int k = 2; k <= NS; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // ---------------- stage 1: differences, early rejects
   logic signed [COORD_W-1:0] ax, ay, bx, by, cx, cy, dx, dy;
   assign ax = req_tdata[0*COORD_W +: COORD_W];
   assign ay = req_tdata[1*COORD_W +: COORD_W];
   assign bx = req_tdata[2*COORD_W +: COORD_W];
   assign by = req_tdata[3*COORD_W +: COORD_W];
   assign cx = req_tdata[4*COORD_W +: COORD_W];
   assign cy = req_tdata[5*COORD_W +: COORD_W];
   assign dx = req_tdata[6*COORD_W +: COORD_W];
   assign dy = req_tdata[7*COORD_W +: COORD_W];

   status_type st1_in, st1_ff;
   logic signed [DIFF_W-1:0] rbx1_ff, rby1_ff, rcx1_ff, rcy1_ff, rdx1_ff, rdy1_ff;
   logic signed [COORD_W-1:0] ax1_ff, ay1_ff;

   always_comb begin
      if ((ax == bx && ay == by) || (cx == dx && cy == dy)) begin
         st1_in = ST_ZERO_LEN;
      end else if ((ax == cx && ay == cy) || (bx == cx && by == cy) ||
                   (ax == dx && ay == dy) || (bx == dx && by == dy)) begin
         st1_in = ST_SHARED;
      end else begin
         st1_in = ST_HIT;
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         st1_ff  <= st1_in;
         ax1_ff  <= ax;
         ay1_ff  <= ay;
         rbx1_ff <= {bx[COORD_W-1], bx} - {ax[COORD_W-1], ax};
         rby1_ff <= {by[COORD_W-1], by} - {ay[COORD_W-1], ay};
         rcx1_ff <= {cx[COORD_W-1], cx} - {ax[COORD_W-1], ax};
         rcy1_ff <= {cy[COORD_W-1], cy} - {ay[COORD_W-1], ay};
         rdx1_ff <= {dx[COORD_W-1], dx} - {ax[COORD_W-1], ax};
         rdy1_ff <= {dy[COORD_W-1], dy} - {ay[COORD_W-1], ay};
      end
   end

   // ---------------- stage 2: products
   status_type st2_ff;
   logic signed [COORD_W-1:0] ax2_ff, ay2_ff;
   logic signed [DIFF_W-1:0]  rbx2_ff, rby2_ff;
   logic signed [PROD_W-1:0]  pc1_ff, pc2_ff, pd1_ff, pd2_ff, pn1_ff, pn2_ff;

   always_ff @(posedge clock) begin
      if (en[2]) begin
         st2_ff  <= st1_ff;
         ax2_ff  <= ax1_ff;
         ay2_ff  <= ay1_ff;
         rbx2_ff <= rbx1_ff;
         rby2_ff <= rby1_ff;
         pc1_ff  <= PROD_W'(rbx1_ff * rcy1_ff);
         pc2_ff  <= PROD_W'(rby1_ff * rcx1_ff);
         pd1_ff  <= PROD_W'(rbx1_ff * rdy1_ff);
         pd2_ff  <= PROD_W'(rby1_ff * rdx1_ff);
         pn1_ff  <= PROD_W'(rcx1_ff * rdy1_ff);
         pn2_ff  <= PROD_W'(rcy1_ff * rdx1_ff);
      end
   end

   // ---------------- stage 3: cross products
   status_type st3_ff;
   logic signed [COORD_W-1:0] ax3_ff, ay3_ff;
   logic signed [DIFF_W-1:0]  rbx3_ff, rby3_ff;
   logic signed [CROSS_W-1:0] sc3_ff, sd3_ff, num3_ff;

   always_ff @(posedge clock) begin
      if (en[3]) begin
         st3_ff  <= st2_ff;
         ax3_ff  <= ax2_ff;
         ay3_ff  <= ay2_ff;
         rbx3_ff <= rbx2_ff;
         rby3_ff <= rby2_ff;
         sc3_ff  <= {pc1_ff[PROD_W-1], pc1_ff} - {pc2_ff[PROD_W-1], pc2_ff};
         sd3_ff  <= {pd1_ff[PROD_W-1], pd1_ff} - {pd2_ff[PROD_W-1], pd2_ff};
         num3_ff <= {pn1_ff[PROD_W-1], pn1_ff} - {pn2_ff[PROD_W-1], pn2_ff};
      end
   end

   // ---------------- stage 4: denominator, side test
   status_type st4_ff;
   logic signed [COORD_W-1:0] ax4_ff, ay4_ff;
   logic signed [DIFF_W-1:0]  rbx4_ff, rby4_ff;
   logic [DEN_W-1:0] den4_ff, num4_ff;

   always_ff @(posedge clock) begin
      if (en[4]) begin
         ax4_ff  <= ax3_ff;
         ay4_ff  <= ay3_ff;
         rbx4_ff <= rbx3_ff;
         rby4_ff <= rby3_ff;
         den4_ff <= {sd3_ff[CROSS_W-1], sd3_ff} - {sc3_ff[CROSS_W-1], sc3_ff};
         num4_ff <= {num3_ff[CROSS_W-1], num3_ff};
         // C on the line counts as non-negative
         if (st3_ff == ST_HIT && sc3_ff[CROSS_W-1] == sd3_ff[CROSS_W-1]) begin
            st4_ff <= ST_NO_CROSS;
         end else begin
            st4_ff <= st3_ff;
         end
      end
   end

   // ---------------- stage 5: make the denominator positive, magnitudes
   status_type st5_ff;
   logic signed [COORD_W-1:0] ax5_ff, ay5_ff;
   logic [COORD_W-1:0] mbx5_ff, mby5_ff;
   logic               nbx5_ff, nby5_ff;
   logic [DEN_W-1:0]   den5_ff, num5_ff;

   always_ff @(posedge clock) begin
      if (en[5]) begin
         st5_ff  <= st4_ff;
         ax5_ff  <= ax4_ff;
         ay5_ff  <= ay4_ff;
         nbx5_ff <= rbx4_ff[DIFF_W-1];
         nby5_ff <= rby4_ff[DIFF_W-1];
         mbx5_ff <= rbx4_ff[DIFF_W-1] ? COORD_W'(-rbx4_ff) : COORD_W'(rbx4_ff);
         mby5_ff <= rby4_ff[DIFF_W-1] ? COORD_W'(-rby4_ff) : COORD_W'(rby4_ff);
         den5_ff <= den4_ff[DEN_W-1] ? -den4_ff : den4_ff;
         num5_ff <= den4_ff[DEN_W-1] ? -num4_ff : num4_ff;
      end
   end

   // ---------------- stage 6: range test, partial products
   status_type st6_ff;
   logic signed [COORD_W-1:0] ax6_ff, ay6_ff;
   logic               nbx6_ff, nby6_ff;
   logic [DEN_W-1:0]   den6_ff;
   logic [COORD_W+LO_W-1:0] pxl6_ff, pxh6_ff, pyl6_ff, pyh6_ff;

   always_ff @(posedge clock) begin
      if (en[6]) begin
         ax6_ff  <= ax5_ff;
         ay6_ff  <= ay5_ff;
         nbx6_ff <= nbx5_ff;
         nby6_ff <= nby5_ff;
         den6_ff <= den5_ff;
         pxl6_ff <= (COORD_W+LO_W)'(mbx5_ff * num5_ff[LO_W-1:0]);
         pxh6_ff <= (COORD_W+LO_W)'(mbx5_ff * num5_ff[DEN_W-1:LO_W]);
         pyl6_ff <= (COORD_W+LO_W)'(mby5_ff * num5_ff[LO_W-1:0]);
         pyh6_ff <= (COORD_W+LO_W)'(mby5_ff * num5_ff[DEN_W-1:LO_W]);
         if (st5_ff == ST_HIT && (num5_ff[DEN_W-1] || num5_ff > den5_ff)) begin
            st6_ff <= ST_OUTSIDE;
         end else begin
            st6_ff <= st5_ff;
         end
      end
   end

   // ---------------- stage 7 and divider: one quotient bit per stage
   status_type                st_d  [0:QUO_W];
   logic signed [COORD_W-1:0] ax_d  [0:QUO_W];
   logic signed [COORD_W-1:0] ay_d  [0:QUO_W];
   logic                      nbx_d [0:QUO_W];
   logic                      nby_d [0:QUO_W];
   logic [DEN_W-1:0]          den_d [0:QUO_W];
   logic [DEN_W-1:0]          rem_d [0:QUO_W][0:1];
   logic [QUO_W-1:0]          nlo_d [0:QUO_W][0:1];
   logic [QUO_W-1:0]          quo_d [0:QUO_W][0:1];

   logic [NUM_W-1:0] nx7_in, ny7_in;
   assign nx7_in = NUM_W'(pxl6_ff) + {pxh6_ff, LO_W'(0)};
   assign ny7_in = NUM_W'(pyl6_ff) + {pyh6_ff, LO_W'(0)};

   always_ff @(posedge clock) begin
      if (en[DIV0]) begin
         st_d[0]     <= st6_ff;
         ax_d[0]     <= ax6_ff;
         ay_d[0]     <= ay6_ff;
         nbx_d[0]    <= nbx6_ff;
         nby_d[0]    <= nby6_ff;
         den_d[0]    <= den6_ff;
         // quotient fits QUO_W bits, so the top part is already below den
         rem_d[0][0] <= nx7_in[NUM_W-1:QUO_W];
         rem_d[0][1] <= ny7_in[NUM_W-1:QUO_W];
         nlo_d[0][0] <= nx7_in[QUO_W-1:0];
         nlo_d[0][1] <= ny7_in[QUO_W-1:0];
         quo_d[0][0] <= '0;
         quo_d[0][1] <= '0;
      end
   end

   for (genvar j = 0; j < QUO_W; j++) begin : g_div
      logic [DEN_W:0] trial [0:1];
      logic           ge    [0:1];

      always_comb begin
         for (int a = 0; a < 2; a++) begin
            trial[a] = {rem_d[j][a], nlo_d[j][a][QUO_W-1]};
            ge[a]    = trial[a] >= {1'b0, den_d[j]};
         end
      end

      always_ff @(posedge clock) begin
         if (en[DIV0+1+j]) begin
            st_d[j+1]  <= st_d[j];
            ax_d[j+1]  <= ax_d[j];
            ay_d[j+1]  <= ay_d[j];
            nbx_d[j+1] <= nbx_d[j];
            nby_d[j+1] <= nby_d[j];
            den_d[j+1] <= den_d[j];
            for (int a = 0; a < 2; a++) begin
               rem_d[j+1][a] <= ge[a] ? DEN_W'(trial[a] - {1'b0, den_d[j]})
                                      : DEN_W'(trial[a]);
               nlo_d[j+1][a] <= {nlo_d[j][a][QUO_W-2:0], 1'b0};
               quo_d[j+1][a] <= {quo_d[j][a][QUO_W-2:0], ge[a]};
            end
         end
      end
   end

   // ---------------- round half away from zero (on magnitude)
   localparam int SR = DIV0 + QUO_W + 1;
   status_type st_r_ff;
   logic signed [COORD_W-1:0] axr_ff, ayr_ff;
   logic nbxr_ff, nbyr_ff;
   logic [QUO_W:0] qxr_ff, qyr_ff;

   always_ff @(posedge clock) begin
      if (en[SR]) begin
         st_r_ff <= st_d[QUO_W];
         axr_ff  <= ax_d[QUO_W];
         ayr_ff  <= ay_d[QUO_W];
         nbxr_ff <= nbx_d[QUO_W];
         nbyr_ff <= nby_d[QUO_W];
         qxr_ff  <= {1'b0, quo_d[QUO_W][0]} +
                    (QUO_W+1)'({rem_d[QUO_W][0], 1'b0} >= {1'b0, den_d[QUO_W]});
         qyr_ff  <= {1'b0, quo_d[QUO_W][1]} +
                    (QUO_W+1)'({rem_d[QUO_W][1], 1'b0} >= {1'b0, den_d[QUO_W]});
      end
   end

   // ---------------- output: add start point, saturate
   localparam int SUM_W = QUO_W + 3;
   localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(2147483647);
   localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

   logic signed [SUM_W-1:0] offx, offy, sumx, sumy;
   logic signed [COORD_W-1:0] px_in, py_in;
   logic hit_in;

   always_comb begin
      offx = $signed({2'b00, qxr_ff});
      offy = $signed({2'b00, qyr_ff});
      if (nbxr_ff) offx = -offx;
      if (nbyr_ff) offy = -offy;
      sumx = offx + SUM_W'(axr_ff);
      sumy = offy + SUM_W'(ayr_ff);
      hit_in = (st_r_ff == ST_HIT);
      if (!hit_in) px_in = '0;
      else if (sumx > SAT_HI) px_in = SAT_HI[COORD_W-1:0];
      else if (sumx < SAT_LO) px_in = SAT_LO[COORD_W-1:0];
      else px_in = sumx[COORD_W-1:0];
      if (!hit_in) py_in = '0;
      else if (sumy > SAT_HI) py_in = SAT_HI[COORD_W-1:0];
      else if (sumy < SAT_LO) py_in = SAT_LO[COORD_W-1:0];
      else py_in = sumy[COORD_W-1:0];
   end

   logic              hit_ff;
   status_type        st_o_ff;
   logic [COORD_W-1:0] px_ff, py_ff;

   always_ff @(posedge clock) begin
      if (en[NS]) begin
         hit_ff  <= hit_in;
         st_o_ff <= st_r_ff;
         px_ff   <= px_in;
         py_ff   <= py_in;
      end
   end

   assign rsp_tvalid = v_ff[NS];
   assign rsp_tdata  = {(RSP_W-2*COORD_W-4)'(0), py_ff, px_ff, st_o_ff, hit_ff};

   // ---------------- checks
   a_hit_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (hit_ff == (st_o_ff == ST_HIT)))
      else $error("hit flag disagrees with status");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !hit_ff) |-> (px_ff == '0 && py_ff == '0))
      else $error("rejected pair carries a nonzero point");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with a free output stage");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

endmodule
`default_nettype wire
